/* rtl/radix_digit_converter_core_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros used by the converter datapath. Clock i_clk, reset i_rst_n.
// ----------------------------------------------------------------------------
`ifndef RADIX_DIGIT_CONVERTER_CORE_MACROS_SVH
`define RADIX_DIGIT_CONVERTER_CORE_MACROS_SVH

// same-cycle implication
`define RDC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RDC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/rdc_pkg.sv */
// ----------------------------------------------------------------------------
// rdc_pkg
// Types, constants and helpers of the radix digit converter.
// ----------------------------------------------------------------------------
`default_nettype none

package rdc_pkg;

    localparam int VALUE_BITS    = 32;
    // accumulator width, capped at 32 bits so no answer needs more than 32 digits
    localparam int ACC_W         = (VALUE_BITS > 32) ? 32 : VALUE_BITS;
    localparam int ACC_EXT_W     = ACC_W + 5;
    localparam int BASE_W        = 5;
    localparam int DIGIT_W       = 4;
    localparam int STORE_DEPTH   = 32;
    localparam int ADDR_W        = $clog2(STORE_DEPTH);
    localparam int CNT_W         = ADDR_W + 1;
    localparam int DIV_BITS_STEP = 4;
    localparam int DIV_STEPS     = (ACC_W + DIV_BITS_STEP - 1) / DIV_BITS_STEP;
    localparam int DIV_W         = DIV_STEPS * DIV_BITS_STEP;
    localparam int STEP_W        = $clog2(DIV_STEPS);

    localparam logic [7:0] ASCII_ZERO = 8'd48;
    localparam logic [7:0] ASCII_NINE = 8'h39;
    localparam logic [7:0] ASCII_A    = 8'h41;
    localparam logic [7:0] ASCII_F    = 8'h46;

    localparam logic [BASE_W-1:0] BASE_MIN = 5'd2;
    localparam logic [BASE_W-1:0] BASE_MAX = 5'd16;
    localparam logic [BASE_W-1:0] IN_BASE_RST  = 5'd10;
    localparam logic [BASE_W-1:0] OUT_BASE_RST = 5'd2;

    // register indexes
    localparam logic CFG_IN_BASE  = 1'b0;
    localparam logic CFG_OUT_BASE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0] digit_char;
        logic       last_in;
    } t_in;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last_out;
        t_status    status;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FINISH,
        S_DIV,
        S_EMIT_RD,
        S_EMIT_OUT
    } t_state;

    typedef struct packed {
        logic acc;       // accumulate the accepted digit
        logic err_out;   // send the error result and clear the number
        logic div_init;  // load the divider from the accumulator
        logic div_step;  // one divider step
        logic emit;      // send one stored digit
    } t_cmd;

    typedef struct packed {
        logic err_set;
        logic conv_done;
        logic cnt_one;
        logic out_free;
    } t_sts;

    // 16 flags a non-digit character
    function automatic logic [BASE_W-1:0] char_to_digit(input logic [7:0] c);
        logic [7:0] t;
        t = 8'd16;
        if (c >= ASCII_ZERO && c <= ASCII_NINE) begin
            t = c - ASCII_ZERO;
        end else if (c >= ASCII_A && c <= ASCII_F) begin
            t = c - ASCII_A + 8'd10;
        end
        return t[BASE_W-1:0];
    endfunction

    function automatic logic [7:0] digit_to_char(input logic [DIGIT_W-1:0] d);
        logic [7:0] t;
        if (d < 4'd10) begin
            t = ASCII_ZERO + 8'(d);
        end else begin
            t = ASCII_A + 8'(d) - 8'd10;
        end
        return t;
    endfunction

    function automatic logic [BASE_W-1:0] eff_base(input logic [BASE_W-1:0] b);
        logic [BASE_W-1:0] t;
        t = b;
        if (b < BASE_MIN) begin
            t = BASE_MIN;
        end else if (b > BASE_MAX) begin
            t = BASE_MAX;
        end
        return t;
    endfunction

endpackage

`default_nettype wire

/* rtl/radix_digit_converter_core.sv */
// ----------------------------------------------------------------------------
// radix_digit_converter_core
// Converts an ASCII digit stream in one base into ASCII digits of another.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid/o_in_ready, i_in): one ASCII digit per beat, most
// significant first, last_in on the least significant digit. Output channel
// (o_out_valid/i_out_ready, o_out): one ASCII digit per beat, most significant
// first, last_out on the final beat; an invalid digit or overflow gives one
// beat with out_char 0 and the error status instead.
// A digit without last_in is accumulated while the sequencer stays idle. After a
// last digit the sequencer passes S_FINISH, then divides once per output digit
// (the divider resolves 4 quotient bits a cycle over the 32-bit value), then
// sends each beat through S_EMIT_RD and S_EMIT_OUT, since each beat reads the
// digit store through its registered read port. The next number is taken once
// the final beat sits in the output register. Reset sets in_base to 10,
// out_base to 2 and drops any number in flight. When the receiver stalls, the
// output register holds its beat and the sequencer waits; no digit is lost.
// Bases are to be written on i_cfg_* while idle, not enforced by the block.
// ----------------------------------------------------------------------------
`default_nettype none

module radix_digit_converter_core (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire rdc_pkg::t_in  i_in,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output rdc_pkg::t_out      o_out,
    input  wire logic          i_cfg_we,
    input  wire logic          i_cfg_index,
    input  wire logic [4:0]    i_cfg_data
);

    import rdc_pkg::*;

    t_cmd cmd;
    t_sts sts;

    rdc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_last_in  (i_in.last_in),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    rdc_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_out_ready),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

/* rtl/rdc_ram.sv */
// ----------------------------------------------------------------------------
// rdc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rdc_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* rtl/rdc_ctrl.sv */
// ----------------------------------------------------------------------------
// rdc_ctrl
// Sequencer: digit intake, conversion by repeated division, digit emit.
// ----------------------------------------------------------------------------
`default_nettype none

module rdc_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_last_in,
    input  wire rdc_pkg::t_sts i_sts,
    output logic               o_in_ready,
    output rdc_pkg::t_cmd      o_cmd
);

    import rdc_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.acc = 1'b1;
                    if (i_last_in) begin
                        n_state = S_FINISH;
                    end
                end
            end
            S_FINISH: begin
                if (i_sts.err_set) begin
                    if (i_sts.out_free) begin
                        o_cmd.err_out = 1'b1;
                        n_state       = S_IDLE;
                    end
                end else begin
                    o_cmd.div_init = 1'b1;
                    n_state        = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.conv_done) begin
                    n_state = S_EMIT_RD;
                end
            end
            S_EMIT_RD: begin
                n_state = S_EMIT_OUT;
            end
            S_EMIT_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = i_sts.cnt_one ? S_IDLE : S_EMIT_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/rdc_datapath.sv */
// ----------------------------------------------------------------------------
// rdc_datapath
// Base registers, accumulator, 4-bit-a-cycle divider, digit store, output beat.
// ----------------------------------------------------------------------------
`default_nettype none
`include "radix_digit_converter_core_macros.svh"

module rdc_datapath (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire rdc_pkg::t_cmd         i_cmd,
    input  wire rdc_pkg::t_in          i_in,
    input  wire logic                  i_cfg_we,
    input  wire logic                  i_cfg_index,
    input  wire logic [4:0]            i_cfg_data,
    input  wire logic                  i_out_ready,
    output rdc_pkg::t_sts              o_sts,
    output logic                       o_out_valid,
    output rdc_pkg::t_out              o_out
);

    import rdc_pkg::*;

    logic [BASE_W-1:0]     r_in_base;
    logic [BASE_W-1:0]     r_out_base;
    logic [ACC_W-1:0]      r_acc;
    t_status               r_err;
    logic [DIV_W-1:0]      r_quo;
    logic [DIGIT_W-1:0]    r_rem;
    logic [STEP_W-1:0]     r_step;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_out_valid;
    t_out                  r_out;

    logic [BASE_W-1:0]     base_in;
    logic [BASE_W-1:0]     base_out;
    logic [BASE_W-1:0]     digit;
    logic [ACC_EXT_W-1:0]  mul_sum;
    logic                  ovf;
    logic [DIV_W-1:0]      n_quo;
    logic [DIGIT_W-1:0]    n_rem;
    logic                  step_last;
    logic [CNT_W-1:0]      cnt_m1;
    logic [DIGIT_W-1:0]    ram_rdata;
    logic                  out_free;

    assign base_in  = eff_base(r_in_base);
    assign base_out = eff_base(r_out_base);
    assign digit    = char_to_digit(i_in.digit_char);
    assign mul_sum  = ACC_EXT_W'(r_acc) * ACC_EXT_W'(base_in) + ACC_EXT_W'(digit);
    assign ovf      = |mul_sum[ACC_EXT_W-1:ACC_W];

    // restoring division, four quotient bits a cycle; remainder stays below base
    always_comb begin
        logic [BASE_W-1:0]     t;
        logic [DIGIT_W-1:0]    rem;
        logic [DIV_W-1:0]      quo;
        rem = r_rem;
        quo = r_quo;
        for (int i = 0; i < DIV_BITS_STEP; i++) begin
            t = {rem, quo[DIV_W-1]};
            if (t >= base_out) begin
                t   = t - base_out;
                quo = {quo[DIV_W-2:0], 1'b1};
            end else begin
                quo = {quo[DIV_W-2:0], 1'b0};
            end
            rem = t[DIGIT_W-1:0];
        end
        n_quo = quo;
        n_rem = rem;
    end

    assign step_last = (r_step == STEP_W'(DIV_STEPS - 1));
    assign cnt_m1    = r_cnt - CNT_W'(1);
    assign out_free  = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_base  <= IN_BASE_RST;
            r_out_base <= OUT_BASE_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_IN_BASE) begin
                r_in_base <= i_cfg_data;
            end else begin
                r_out_base <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_err <= ST_OK;
        end else if (i_cmd.acc) begin
            if (r_err == ST_OK) begin
                if (digit >= base_in) begin
                    r_err <= ST_INVALID;
                end else if (ovf) begin
                    r_err <= ST_OVERFLOW;
                end else begin
                    r_acc <= mul_sum[ACC_W-1:0];
                end
            end
        end else if (i_cmd.err_out || i_cmd.div_init) begin
            r_acc <= '0;
            r_err <= ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem  <= '0;
            r_step <= '0;
            r_cnt  <= '0;
        end else if (i_cmd.div_init) begin
            r_rem  <= '0;
            r_step <= '0;
            r_cnt  <= '0;
        end else if (i_cmd.div_step) begin
            if (step_last) begin
                r_rem  <= '0;
                r_step <= '0;
                r_cnt  <= r_cnt + CNT_W'(1);
            end else begin
                r_rem  <= n_rem;
                r_step <= r_step + STEP_W'(1);
            end
        end else if (i_cmd.emit) begin
            r_cnt <= cnt_m1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_quo <= DIV_W'(r_acc);
        end else if (i_cmd.div_step) begin
            r_quo <= n_quo;
        end
    end

    // digits land least significant first, read back from the top
    rdc_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.div_step && step_last),
        .i_waddr (r_cnt[ADDR_W-1:0]),
        .i_wdata (n_rem),
        .i_raddr (cnt_m1[ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.err_out || i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.err_out) begin
            r_out.out_char <= '0;
            r_out.last_out <= 1'b1;
            r_out.status   <= r_err;
        end else if (i_cmd.emit) begin
            r_out.out_char <= digit_to_char(ram_rdata);
            r_out.last_out <= (r_cnt == CNT_W'(1));
            r_out.status   <= ST_OK;
        end
    end

    assign o_sts.err_set   = (r_err != ST_OK);
    assign o_sts.conv_done = step_last
                           && ((n_quo == '0) || (r_cnt == CNT_W'(STORE_DEPTH - 1)));
    assign o_sts.cnt_one   = (r_cnt == CNT_W'(1));
    assign o_sts.out_free  = out_free;
    assign o_out_valid     = r_out_valid;
    assign o_out           = r_out;

    `RDC_ASSERT_NOW(a_rem_below_base, 1'b1, ({1'b0, r_rem} < base_out),
                    "remainder not below base")
    `RDC_ASSERT_NOW(a_cnt_in_range, 1'b1, (r_cnt <= CNT_W'(STORE_DEPTH)),
                    "digit count too big")
    `RDC_ASSERT_NOW(a_err_beat, (r_out_valid && r_out.status != ST_OK),
                    (r_out.out_char == '0 && r_out.last_out), "bad error beat")
    `RDC_ASSERT_NEXT(a_acc_frozen, (r_err != ST_OK && !i_cmd.err_out && !i_cmd.div_init),
                     $stable(r_acc), "accumulator moved after error")

endmodule

`default_nettype wire
